FILE: rtl/core/assert_macros.svh
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/sasi_pkg.sv
// ----------------------------------------------------------------------------
// sasi_pkg
// Shared types and constants of the six-axis servo interpolator.
// ----------------------------------------------------------------------------
package sasi_pkg;
	localparam int AXES      = 6;
	localparam int FRAC_BITS = 16;
	localparam int POS_W     = 7 + FRAC_BITS;
	localparam int INC_W     = POS_W + 1;
	localparam int MAX_STEPS = 255;
	localparam int CNT_W     = 8;
	localparam int OFF_W     = 12;
	localparam int PCT_W     = 8;

	localparam logic [PCT_W-1:0] GRIP_RESET = 8'd32;
	localparam logic [PCT_W-1:0] PCT_MAX    = 8'd100;

	localparam logic REQ_MOVE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef logic [OFF_W-1:0] stagger_arr_t [AXES];
	localparam stagger_arr_t STAGGER = '{12'd1515, 12'd2047, 12'd1515,
		12'd2539, 12'd1023, 12'd2047};

	typedef struct packed {
		logic                 req_type;
		logic [CNT_W-1:0]     step_count;
		logic [PCT_W-1:0]     base_target;
		logic [PCT_W-1:0]     joint1_target;
		logic [PCT_W-1:0]     joint2_target;
		logic [PCT_W-1:0]     joint3_target;
		logic [PCT_W-1:0]     wrist_target;
		logic [PCT_W-1:0]     gripper_target;
	} req_t;

	typedef struct packed {
		logic [OFF_W-1:0] base_off;
		logic [OFF_W-1:0] joint1_off;
		logic [OFF_W-1:0] joint2_off;
		logic [OFF_W-1:0] joint3_off;
		logic [OFF_W-1:0] wrist_off;
		logic [OFF_W-1:0] gripper_off;
		logic             move_done;
		logic             range_error;
	} rsp_t;

	// Divider control between the sequencer and the serial divider.
	typedef struct packed {
		logic             start;
		logic [INC_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [INC_W-1:0] quotient;
	} div_rsp_t;
endpackage

FILE: rtl/core/sasi_stream_if.sv
// ----------------------------------------------------------------------------
// sasi_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface sasi_stream_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/sasi_div.sv
// ----------------------------------------------------------------------------
// sasi_div
// Bit-serial signed divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module sasi_div (
	input  logic               clk,
	input  logic               arst_n,
	input  sasi_pkg::div_req_t req,
	output sasi_pkg::div_rsp_t rsp
);
	import sasi_pkg::*;

	localparam int BIT_W = $clog2(INC_W + 1);

	logic [INC_W-1:0] quo_q;
	logic [CNT_W:0]   rem_q;
	logic [CNT_W-1:0] den_q;
	logic             neg_q;
	logic [BIT_W-1:0] bits_q;
	logic             busy_q;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   rem_sh;

	assign rem_sh = {rem_q[CNT_W-1:0], quo_q[INC_W-1]};
	assign trial  = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			bits_q   <= '0;
			rsp.done <= 1'b0;
		end else begin
			rsp.done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				bits_q <= BIT_W'(INC_W);
			end else if (busy_q) begin
				bits_q <= bits_q - 1'b1;
				if (bits_q == BIT_W'(1)) begin
					busy_q   <= 1'b0;
					rsp.done <= 1'b1;
				end
			end
		end
	end

	// The magnitude is shifted out of the top of quo_q while quotient bits enter below.
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[INC_W-1];
			quo_q <= req.dividend[INC_W-1] ? -req.dividend : req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[CNT_W]) begin
				rem_q <= trial;
				quo_q <= {quo_q[INC_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[INC_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.quotient = neg_q ? -quo_q : quo_q;
endmodule

FILE: rtl/core/sasi_offtime.sv
// ----------------------------------------------------------------------------
// sasi_offtime
// Converts one fixed-point position to a PWM off-time with stagger.
// ----------------------------------------------------------------------------
module sasi_offtime (
	input  logic                              clk,
	input  logic [sasi_pkg::POS_W-1:0]        pos,
	input  logic [2:0]                        axis,
	output logic [sasi_pkg::OFF_W-1:0]        off
);
	import sasi_pkg::*;

	// off = floor((2*(98304*2^F + 4096*pos) + 1000*2^F) / (2000*2^F))
	//     = floor((197608*2^F + 8192*pos) / (2000*2^F))
	// num / 2^F is exact enough: take x = 197608 + 8192*pos/2^F, then floor(x/2000).
	// We keep full precision: n = 197608*2^F + 8192*pos, q = floor(n / (2000*2^F)).
	localparam int NUM_W = POS_W + 14 + 1;
	localparam logic [NUM_W-1:0] BIAS = NUM_W'(64'd197608 << FRAC_BITS);
	localparam int RECIP_SH = 31;
	// q = floor(n/2^(F+4) / 125); m = n >> (F+4) is exact for the floor.
	localparam int M_W = NUM_W - FRAC_BITS - 4;

	logic [NUM_W-1:0] num;
	logic [M_W-1:0]   m_s1;
	logic [2:0]       axis_s1;
	logic [M_W+RECIP_SH:0] prod;
	logic [M_W-1:0]   q;
	logic [M_W+7:0]   back;

	assign num = BIAS + (NUM_W'(pos) << 13);

	always_ff @(posedge clk) begin
		m_s1    <= num[NUM_W-1:FRAC_BITS+4];
		axis_s1 <= axis;
	end

	// Reciprocal estimate of /125 with one correction step.
	assign prod = (M_W+RECIP_SH+1)'(m_s1) * (M_W+RECIP_SH+1)'(32'd17179870);
	always_comb begin
		q    = M_W'(prod >> RECIP_SH);
		back = (M_W+8)'(q) * (M_W+8)'(125);
		if ((M_W+8)'(m_s1) >= back + (M_W+8)'(125))
			q = q + 1'b1;
		else if ((M_W+8)'(m_s1) < back)
			q = q - 1'b1;
	end

	assign off = OFF_W'(q) + STAGGER[axis_s1];
endmodule

FILE: rtl/core/six_axis_servo_interpolator_top.sv
// ----------------------------------------------------------------------------
// six_axis_servo_interpolator_top
// Six-axis linear interpolator producing staggered PWM off-times.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req, one transaction each; req_type selects a
// move command or an update tick. Results leave on rsp, at most one per
// request, and the block handles one request at a time.
// A move that needs interpolation computes six increments, one axis after
// another, on one shared bit-serial divider; no result is produced, and
// the next request is taken once the last increment is stored.
// A tick that advances the axes passes each axis through ST_EMIT,
// ST_EMIT_WAIT and ST_ADV on the off-time unit and the stepper before its
// result is presented from ST_OUT. A final tick or an already-reached move
// passes each axis through ST_EMIT and ST_EMIT_WAIT only; a rejected move
// presents its result on the following cycle. Once the result is taken
// the block returns to ST_IDLE and the next request can be accepted.
// Reset places every axis at zero but the gripper at 32 percent, with no
// move active. While the receiver stalls the result stays in the output
// register and no request is accepted. Out-of-range targets yield one
// result with range_error set and leave the motion state untouched.
// ----------------------------------------------------------------------------
module six_axis_servo_interpolator_top (
	input logic clk,
	input logic arst_n,
	sasi_stream_if.sink   req,
	sasi_stream_if.source rsp
);
	import sasi_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV, ST_DIV_WAIT, ST_EMIT, ST_EMIT_WAIT, ST_ADV, ST_OUT
	} state_t;

	state_t state_q;
	logic [POS_W-1:0] pos_q  [AXES];
	logic [INC_W-1:0] inc_q  [AXES];
	logic [6:0]       goal_q [AXES];
	logic [CNT_W-1:0] steps_q;
	logic             active_q;
	logic [2:0]       ax_q;
	logic             done_q;
	logic [PCT_W-1:0] tgt_q  [AXES];
	logic [CNT_W-1:0] n_q;
	logic [OFF_W-1:0] off_res_q [AXES];
	logic             advance_q;

	div_req_t         dreq;
	div_rsp_t         drsp;
	logic [OFF_W-1:0] off;
	logic [PCT_W-1:0] tgt_in [AXES];
	logic             bad;
	logic             moving;
	logic [INC_W-1:0] diff;
	logic [INC_W:0]   stepped;

	assign tgt_in[0] = req.data.base_target;
	assign tgt_in[1] = req.data.joint1_target;
	assign tgt_in[2] = req.data.joint2_target;
	assign tgt_in[3] = req.data.joint3_target;
	assign tgt_in[4] = req.data.wrist_target;
	assign tgt_in[5] = req.data.gripper_target;

	always_comb begin
		bad = 1'b0;
		moving = 1'b0;
		for (int a = 0; a < AXES; a++) begin
			if (tgt_in[a] > PCT_MAX)
				bad = 1'b1;
			if (pos_q[a] != {tgt_in[a][6:0], {FRAC_BITS{1'b0}}})
				moving = 1'b1;
		end
	end

	assign diff = {1'b0, pos_q[ax_q]} - {1'b0, tgt_q[ax_q][6:0], {FRAC_BITS{1'b0}}};
	assign stepped = {1'b0, {1'b0, pos_q[ax_q]}} - {inc_q[ax_q][INC_W-1], inc_q[ax_q]};

	sasi_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	sasi_offtime u_off (.clk(clk), .pos(pos_q[ax_q]), .axis(ax_q), .off(off));

	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			active_q  <= 1'b0;
			steps_q   <= '0;
			ax_q      <= '0;
			done_q    <= 1'b0;
			advance_q <= 1'b0;
			rsp.valid <= 1'b0;
			rsp.data  <= '0;
			dreq.start <= 1'b0;
			for (int a = 0; a < AXES; a++) begin
				pos_q[a]  <= '0;
				inc_q[a]  <= '0;
				goal_q[a] <= '0;
			end
			pos_q[AXES-1]  <= {GRIP_RESET[6:0], {FRAC_BITS{1'b0}}};
			goal_q[AXES-1] <= GRIP_RESET[6:0];
		end else begin
			dreq.start <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						ax_q <= '0;
						if (req.data.req_type == REQ_MOVE) begin
							if (bad) begin
								rsp.data  <= '{range_error: 1'b1, default: '0};
								rsp.valid <= 1'b1;
								state_q   <= ST_OUT;
							end else begin
								for (int a = 0; a < AXES; a++) begin
									goal_q[a] <= tgt_in[a][6:0];
									tgt_q[a]  <= tgt_in[a];
								end
								n_q <= (req.data.step_count == '0) ? CNT_W'(1)
									: req.data.step_count;
								if (!moving) begin
									for (int a = 0; a < AXES; a++) begin
										pos_q[a] <= {tgt_in[a][6:0], {FRAC_BITS{1'b0}}};
										inc_q[a] <= '0;
									end
									active_q  <= 1'b0;
									steps_q   <= '0;
									done_q    <= 1'b1;
									advance_q <= 1'b0;
									state_q   <= ST_EMIT;
								end else begin
									state_q <= ST_DIV;
								end
							end
						end else if (active_q) begin
							if (steps_q != '0) begin
								done_q    <= 1'b0;
								advance_q <= 1'b1;
							end else begin
								for (int a = 0; a < AXES; a++) begin
									pos_q[a] <= {goal_q[a], {FRAC_BITS{1'b0}}};
									inc_q[a] <= '0;
								end
								active_q  <= 1'b0;
								done_q    <= 1'b1;
								advance_q <= 1'b0;
							end
							state_q <= ST_EMIT;
						end
					end
				end
				ST_DIV: begin
					dreq.start    <= 1'b1;
					dreq.dividend <= diff;
					dreq.divisor  <= n_q;
					state_q       <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (drsp.done) begin
						inc_q[ax_q] <= drsp.quotient;
						if (ax_q == 3'(AXES-1)) begin
							steps_q  <= n_q;
							active_q <= 1'b1;
							state_q  <= ST_IDLE;
						end else begin
							ax_q    <= ax_q + 1'b1;
							state_q <= ST_DIV;
						end
					end
				end
				ST_EMIT: begin
					state_q <= ST_EMIT_WAIT;
				end
				ST_EMIT_WAIT: begin
					off_res_q[ax_q] <= off;
					if (advance_q) begin
						state_q <= ST_ADV;
					end else if (ax_q == 3'(AXES-1)) begin
						state_q <= ST_OUT;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= ST_EMIT;
					end
				end
				ST_ADV: begin
					pos_q[ax_q] <= stepped[INC_W] ? '0 : stepped[POS_W-1:0];
					if (ax_q == 3'(AXES-1)) begin
						steps_q <= steps_q - 1'b1;
						state_q <= ST_OUT;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= ST_EMIT;
					end
				end
				ST_OUT: begin
					if (!rsp.valid && !rsp.data.range_error) begin
						rsp.data.base_off    <= off_res_q[0];
						rsp.data.joint1_off  <= off_res_q[1];
						rsp.data.joint2_off  <= off_res_q[2];
						rsp.data.joint3_off  <= off_res_q[3];
						rsp.data.wrist_off   <= off_res_q[4];
						rsp.data.gripper_off <= off_res_q[5];
						rsp.data.move_done   <= done_q;
						rsp.data.range_error <= 1'b0;
						rsp.valid            <= 1'b1;
					end else if (rsp.valid && rsp.ready) begin
						rsp.valid <= 1'b0;
						rsp.data.range_error <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/core/sasi_checker.sv
// ----------------------------------------------------------------------------
// sasi_checker
// Port-level checks of the servo interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sasi_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_done,
	input logic rsp_err
);
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
	`ASSERT_IMPL(a_one_at_time, clk, arst_n, rsp_valid, !req_ready, "request taken while a result waits")
	`ASSERT_IMPL(a_err_excl, clk, arst_n, rsp_valid && rsp_err, !rsp_done, "error result marked done")
	`ASSERT_NEXT(a_data_hold, clk, arst_n, rsp_valid && !rsp_ready, $stable(rsp_done) && $stable(rsp_err), "result changed while stalled")
endmodule

bind six_axis_servo_interpolator_top sasi_checker u_sasi_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_done(rsp.data.move_done), .rsp_err(rsp.data.range_error)
);

FILE: test/six_axis_servo_interpolator_top_tb.sv
// ----------------------------------------------------------------------------
// six_axis_servo_interpolator_top_tb
// Self-checking bench for the six-axis servo interpolator. A directed table
// covers reset state, range errors, zero counts and moves that are already
// at target. Random move and tick sequences follow. Every result is compared
// as a whole against an in-bench model of the interpolation.
// ----------------------------------------------------------------------------
module six_axis_servo_interpolator_top_tb;
	import sasi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM    = 1530;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	sasi_stream_if #(.payload_t(req_t)) req_ch (clk);
	sasi_stream_if #(.payload_t(rsp_t)) rsp_ch (clk);

	six_axis_servo_interpolator_top dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .rsp(rsp_ch.source)
	);

	// Model state.
	logic [POS_W-1:0] pos [AXES];
	logic signed [INC_W:0] inc [AXES];
	logic [PCT_W-1:0] goal [AXES];
	int unsigned remaining;
	bit moving;

	rsp_t pending_rsp[$];
	int mismatches = 0;
	int results_seen = 0;
	int moves_sent = 0;
	int ticks_sent = 0;
	int cycles = 0;

	function automatic logic [OFF_W-1:0] pwm_off(int ax, logic [POS_W-1:0] p);
		longint unsigned one, num;
		one = 64'd1 << FRAC_BITS;
		num = 2 * (98304 * one + 4096 * longint'(p)) + 1000 * one;
		return OFF_W'(num / (2000 * one) + STAGGER[ax]);
	endfunction

	function automatic rsp_t servo_outputs(bit done);
		rsp_t r;
		logic [OFF_W-1:0] o [AXES];
		for (int a = 0; a < AXES; a++) o[a] = pwm_off(a, pos[a]);
		r = '{o[0], o[1], o[2], o[3], o[4], o[5], done, 1'b0};
		return r;
	endfunction

	task automatic snap_to_goal();
		for (int a = 0; a < AXES; a++) begin
			pos[a] = POS_W'({goal[a]} << FRAC_BITS);
			inc[a] = '0;
		end
	endtask

	task automatic model_reset();
		for (int a = 0; a < AXES; a++) begin
			pos[a] = '0;
			inc[a] = '0;
			goal[a] = '0;
		end
		pos[AXES-1] = POS_W'({GRIP_RESET} << FRAC_BITS);
		goal[AXES-1] = GRIP_RESET;
		remaining = 0;
		moving = 0;
	endtask

	task automatic interpolate(req_t q);
		logic [PCT_W-1:0] t [AXES];
		longint d, p;
		int unsigned n;
		bit bad, away;
		t = '{q.base_target, q.joint1_target, q.joint2_target, q.joint3_target,
			q.wrist_target, q.gripper_target};
		if (q.req_type == REQ_MOVE) begin
			bad = 0;
			away = 0;
			foreach (t[a]) if (t[a] > PCT_MAX) bad = 1;
			if (bad) begin
				pending_rsp.push_back('{default: '0, range_error: 1'b1});
				return;
			end
			n = (q.step_count == 0) ? 1 : q.step_count;
			if (n > MAX_STEPS) n = MAX_STEPS;
			for (int a = 0; a < AXES; a++) begin
				goal[a] = t[a];
				if (longint'(pos[a]) != (longint'(t[a]) << FRAC_BITS)) away = 1;
			end
			if (!away) begin
				snap_to_goal();
				moving = 0;
				remaining = 0;
				pending_rsp.push_back(servo_outputs(1));
				return;
			end
			for (int a = 0; a < AXES; a++) begin
				d = longint'(pos[a]) - (longint'(t[a]) << FRAC_BITS);
				inc[a] = d / longint'(n);
			end
			remaining = n;
			moving = 1;
		end else if (moving) begin
			if (remaining > 0) begin
				pending_rsp.push_back(servo_outputs(0));
				for (int a = 0; a < AXES; a++) begin
					p = longint'(pos[a]) - longint'(inc[a]);
					if (p < 0) p = 0;
					pos[a] = POS_W'(p);
				end
				remaining--;
			end else begin
				snap_to_goal();
				moving = 0;
				pending_rsp.push_back(servo_outputs(1));
			end
		end
	endtask

	// Directed table; expected value typed in where it is obvious.
	typedef struct {
		req_t q;
		bit   fixed;
		rsp_t r;
	} vector_t;

	localparam rsp_t RANGE_ERR = '{default: '0, range_error: 1'b1};
	// Reset positions: all axes at zero, gripper at 32 percent.
	localparam rsp_t AT_RESET = '{12'd1613, 12'd2145, 12'd1613, 12'd2637,
		12'd1121, 12'd2276, 1'b1, 1'b0};
	localparam rsp_t AT_FULL = '{12'd2023, 12'd2555, 12'd2023, 12'd3047,
		12'd1531, 12'd2555, 1'b1, 1'b0};

	vector_t table_rows [$];

	task automatic add_row(bit rt, int n, int b, int j1, int j2, int j3, int w, int g,
		bit fx = 0, rsp_t r = '0);
		vector_t v;
		v.q = '{rt, 8'(n), 8'(b), 8'(j1), 8'(j2), 8'(j3), 8'(w), 8'(g)};
		v.fixed = fx;
		v.r = r;
		table_rows.push_back(v);
	endtask

	task automatic build_table();
		add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 0);                // idle tick
		add_row(REQ_MOVE, 5, 0, 0, 0, 0, 0, 32, 1, AT_RESET);  // already there
		add_row(REQ_MOVE, 3, 101, 0, 0, 0, 0, 0, 1, RANGE_ERR);
		add_row(REQ_MOVE, 3, 0, 0, 0, 0, 0, 255, 1, RANGE_ERR);
		add_row(REQ_MOVE, 255, 255, 255, 255, 255, 255, 255, 1, RANGE_ERR);
		add_row(REQ_MOVE, 0, 100, 100, 100, 100, 100, 100);    // zero count
		add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 0);
		add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 0);
		add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 0);
		add_row(REQ_MOVE, 255, 100, 100, 100, 100, 100, 100, 1, AT_FULL);
		add_row(REQ_MOVE, 3, 0, 100, 7, 55, 0, 100);
		add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 0);
		add_row(REQ_MOVE, 1, 200, 0, 0, 0, 0, 0, 1, RANGE_ERR); // move carries on
		add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 0);
		add_row(REQ_MOVE, 2, 50, 50, 50, 50, 50, 50);          // restart mid-move
		add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 0);
		add_row(REQ_MOVE, 7, 0, 0, 0, 0, 0, 0);                // cancels by new move
		for (int i = 0; i < 8; i++) add_row(REQ_TICK, 255, 255, 255, 255, 255, 255, 255);
	endtask

	function automatic req_t random_request(bit in_sequence);
		req_t q;
		logic [PCT_W-1:0] t [AXES];
		int mode;
		q.req_type = REQ_MOVE;
		q.step_count = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
		mode = $urandom_range(0, 19);
		foreach (t[a]) begin
			if (mode == 0) t[a] = 8'($urandom);
			else if (mode < 3) t[a] = goal[a];
			else t[a] = ($urandom_range(0, 3) == 0) ? (($urandom & 1) ? 8'd100 : 8'd0)
				: 8'($urandom_range(0, 100));
		end
		q = '{REQ_MOVE, q.step_count, t[0], t[1], t[2], t[3], t[4], t[5]};
		if (in_sequence) begin
			q.req_type = REQ_TICK;
			q.step_count = 8'($urandom);
			q.base_target = 8'($urandom);
		end
		return q;
	endfunction

	task automatic send(req_t q);
		req_ch.valid <= 1'b1;
		req_ch.data <= q;
		do @(posedge clk); while (!req_ch.ready);
		interpolate(q);
		if (q.req_type == REQ_MOVE) moves_sent++;
		else ticks_sent++;
		@(negedge clk);
	endtask

	task automatic idle_gap();
		req_ch.valid <= 1'b0;
		repeat ($urandom_range(1, 12)) @(negedge clk);
	endtask

	// Receiver stall pattern.
	int stall_mode = 0;
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
			2: rsp_ch.ready <= ($urandom_range(0, 1) != 0);
			default: rsp_ch.ready <= ($urandom_range(0, 9) == 0);
		endcase
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			results_seen++;
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", rsp_ch.data);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_ch.data !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, rsp_ch.data);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL six_axis_servo_interpolator_top");
			$finish;
		end
	end

	initial begin
		int burst, ticks;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		model_reset();
		build_table();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (table_rows[i]) begin
			if (table_rows[i].fixed) begin
				send(table_rows[i].q);
				// The typed-in value must agree with the modelled one.
				if (pending_rsp[$] !== table_rows[i].r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("table row %0d: expected %p, model %p", i,
							table_rows[i].r, pending_rsp[$]);
				end
			end else send(table_rows[i].q);
			if ($urandom_range(0, 2) == 0) idle_gap();
		end

		burst = $urandom_range(1, 20);
		for (int i = 0; i < N_RANDOM; i++) begin
			// Mostly a move followed by enough ticks to finish it, sometimes cut short.
			if (!moving || $urandom_range(0, 15) == 0) send(random_request(0));
			else begin
				ticks = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : remaining + 1;
				if (ticks == 0) ticks = 1;
				for (int k = 0; k < ticks && i < N_RANDOM; k++, i++) send(random_request(1));
				// The outer loop counts the last tick of the group.
				i--;
			end
			if (--burst <= 0) begin
				idle_gap();
				burst = $urandom_range(1, 20);
			end
		end
		req_ch.valid <= 1'b0;

		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d moves and %0d ticks; %0d results checked.",
			moves_sent, ticks_sent, results_seen);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("PASS six_axis_servo_interpolator_top");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAIL six_axis_servo_interpolator_top");
		end
		$finish;
	end
endmodule

FILE: six_axis_servo_interpolator_top.f
+incdir+rtl/core
rtl/core/sasi_pkg.sv
rtl/core/sasi_stream_if.sv
rtl/core/sasi_div.sv
rtl/core/sasi_offtime.sv
rtl/core/six_axis_servo_interpolator_top.sv
rtl/core/sasi_checker.sv
test/six_axis_servo_interpolator_top_tb.sv
